@@ rtl/tpce_pkg.sv @@
// ----------------------------------------------------------------------------
// tpce_pkg: shared types and constants of the trie prefix count engine
// Pool geometry, item and result layouts, mode and status codes, and the
// command and status groups between controller and datapath.
// ----------------------------------------------------------------------------
package tpce_pkg;

	localparam int NODE_POOL  = 4096;
	localparam int ALPHABET   = 26;
	localparam int COUNT_BITS = 16;

	localparam int NODE_W  = $clog2(NODE_POOL);
	localparam int FREE_W  = NODE_W + 1;
	localparam int SLOTS   = NODE_POOL * ALPHABET;
	localparam int SLOT_W  = $clog2(SLOTS);
	localparam int SCORE_W = 32;

	localparam logic [1:0] MODE_INSERT = 2'd0;
	localparam logic [1:0] MODE_QUERY  = 2'd1;
	localparam logic [1:0] MODE_CLEAR  = 2'd2;

	localparam logic [1:0] ST_OK           = 2'd0;
	localparam logic [1:0] ST_POOL_FULL    = 2'd1;
	localparam logic [1:0] ST_PATH_MISSING = 2'd2;

	typedef logic [NODE_W-1:0]     node_t;
	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [ALPHABET-1:0]   row_t;

	typedef struct packed {
		logic [1:0] mode;
		logic [4:0] letter;
		logic       word_end;
	} item_t;

	typedef struct packed {
		logic [SCORE_W-1:0] score;
		logic [1:0]         status;
	} result_t;

	typedef struct packed {
		logic accept;
		logic look;
		logic count;
		logic skip;
		logic clear;
	} cmd_t;

	typedef struct packed {
		logic hit;
		logic skip_item;
		logic clr_last;
	} sts_t;

endpackage

@@ rtl/tpce_ctrl.sv @@
// ----------------------------------------------------------------------------
// tpce_ctrl: sequencing of the trie prefix count engine
// Steps each letter through lookup and count phases and runs the valid-row
// clearing sweep after reset and after a clear item.
// ----------------------------------------------------------------------------
module tpce_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic [1:0]          mode,
	input  tpce_pkg::sts_t      sts,
	output tpce_pkg::cmd_t      cmd,
	output logic                busy
);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_LOOK,
		S_COUNT,
		S_SKIP
	} state_t;

	state_t state_q, state_d;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (sts.clr_last)
					state_d = S_IDLE;
			end
			S_IDLE: begin
				if (start) begin
					if (mode == tpce_pkg::MODE_CLEAR)
						state_d = S_CLEAR;
					else if (mode == tpce_pkg::MODE_INSERT || mode == tpce_pkg::MODE_QUERY)
						state_d = sts.skip_item ? S_SKIP : S_LOOK;
				end
			end
			S_LOOK: begin
				state_d = sts.hit ? S_COUNT : S_IDLE;
			end
			S_COUNT: state_d = S_IDLE;
			S_SKIP:  state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.accept = (state_q == S_IDLE) && start;
		cmd.look   = (state_q == S_LOOK);
		cmd.count  = (state_q == S_COUNT);
		cmd.skip   = (state_q == S_SKIP);
		cmd.clear  = (state_q == S_CLEAR);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			busy    <= 1'b1;
		end else begin
			state_q <= state_d;
			busy    <= (state_d != S_IDLE);
		end
	end

	a_count_after_look: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_COUNT |-> $past(state_q) == S_LOOK)
		else $error("count phase entered without a lookup");

	a_letter_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && (mode == tpce_pkg::MODE_INSERT || mode == tpce_pkg::MODE_QUERY)
		|=> busy)
		else $error("letter transfer did not hold the engine busy");

	a_clear_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && mode == tpce_pkg::MODE_CLEAR |=> state_q == S_CLEAR)
		else $error("clear item did not start the sweep");

endmodule

@@ rtl/tpce_datapath.sv @@
// ----------------------------------------------------------------------------
// tpce_datapath: node pool memories and word state of the trie engine
// Holds the child links, per-node valid rows and prefix counts, the current
// node, the free pointer, the running score and the word status.
// ----------------------------------------------------------------------------
module tpce_datapath (
	input  logic                clk,
	input  logic                arst_n,
	input  tpce_pkg::item_t     item,
	input  tpce_pkg::cmd_t      cmd,
	output tpce_pkg::sts_t      sts,
	output logic                done,
	output tpce_pkg::result_t   result
);

	localparam tpce_pkg::count_t COUNT_MAX = '1;

	tpce_pkg::node_t  link_mem [tpce_pkg::SLOTS];
	tpce_pkg::row_t   vrow_mem [tpce_pkg::NODE_POOL];
	tpce_pkg::count_t cnt_mem  [tpce_pkg::NODE_POOL];

	tpce_pkg::item_t                item_q;
	logic [tpce_pkg::SLOT_W-1:0]    slot_q;
	tpce_pkg::node_t                link_rd;
	tpce_pkg::row_t                 row_rd;
	tpce_pkg::count_t               cnt_rd;
	tpce_pkg::node_t                cur_q;
	logic [tpce_pkg::FREE_W-1:0]    next_free_q;
	logic [tpce_pkg::SCORE_W-1:0]   score_q;
	logic [1:0]                     status_q;
	tpce_pkg::node_t                clr_cnt_q;
	logic                           done_q;
	tpce_pkg::result_t              result_q;

	logic [tpce_pkg::SLOT_W-1:0]    slot_addr;
	logic                           hit;
	logic                           pool_full;
	logic                           alloc;
	logic                           commit;
	tpce_pkg::count_t               cnt_inc;
	logic [tpce_pkg::SCORE_W:0]     score_sum;
	logic [tpce_pkg::SCORE_W-1:0]   score_sat;
	logic [1:0]                     nx_status;
	logic [tpce_pkg::SCORE_W-1:0]   nx_score;
	tpce_pkg::node_t                nx_cur;

	assign slot_addr = tpce_pkg::SLOT_W'(cur_q) * tpce_pkg::SLOT_W'(tpce_pkg::ALPHABET)
		+ tpce_pkg::SLOT_W'(item.letter);

	assign hit       = row_rd[item_q.letter];
	assign pool_full = next_free_q >= tpce_pkg::FREE_W'(tpce_pkg::NODE_POOL);
	assign alloc     = cmd.look && !hit && item_q.mode == tpce_pkg::MODE_INSERT && !pool_full;
	assign commit    = cmd.skip || cmd.count || (cmd.look && !hit);

	assign cnt_inc   = (cnt_rd == COUNT_MAX) ? cnt_rd : cnt_rd + 1'b1;
	assign score_sum = (tpce_pkg::SCORE_W + 1)'(score_q) + (tpce_pkg::SCORE_W + 1)'(cnt_rd);
	assign score_sat = score_sum[tpce_pkg::SCORE_W] ? '1 : score_sum[tpce_pkg::SCORE_W-1:0];

	assign sts.hit       = hit;
	assign sts.skip_item = (status_q != tpce_pkg::ST_OK)
		|| (item.letter >= 5'(tpce_pkg::ALPHABET));
	assign sts.clr_last  = (clr_cnt_q == tpce_pkg::NODE_W'(tpce_pkg::NODE_POOL - 1));

	// Outcome of the letter being finished, before the word-end return to root.
	always_comb begin
		nx_status = status_q;
		nx_score  = score_q;
		nx_cur    = cur_q;
		if (cmd.skip) begin
			if (status_q == tpce_pkg::ST_OK)
				nx_status = tpce_pkg::ST_PATH_MISSING;
		end else if (cmd.look) begin
			if (item_q.mode == tpce_pkg::MODE_INSERT) begin
				if (pool_full)
					nx_status = tpce_pkg::ST_POOL_FULL;
				else
					nx_cur = next_free_q[tpce_pkg::NODE_W-1:0];
			end else begin
				nx_status = tpce_pkg::ST_PATH_MISSING;
			end
		end else if (cmd.count) begin
			nx_cur = link_rd;
			if (item_q.mode == tpce_pkg::MODE_QUERY)
				nx_score = score_sat;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			item_q  <= item;
			slot_q  <= slot_addr;
			link_rd <= link_mem[slot_addr];
		end
		if (alloc)
			link_mem[slot_q] <= next_free_q[tpce_pkg::NODE_W-1:0];
	end

	always_ff @(posedge clk) begin
		if (cmd.accept)
			row_rd <= vrow_mem[cur_q];
		if (cmd.clear)
			vrow_mem[clr_cnt_q] <= '0;
		else if (alloc)
			vrow_mem[cur_q] <= row_rd | (tpce_pkg::ALPHABET'(1) << item_q.letter);
	end

	// A fresh node starts at count one, since its insert raises it at once.
	always_ff @(posedge clk) begin
		if (cmd.look && hit)
			cnt_rd <= cnt_mem[link_rd];
		if (alloc)
			cnt_mem[next_free_q[tpce_pkg::NODE_W-1:0]] <= tpce_pkg::COUNT_BITS'(1);
		else if (cmd.count && item_q.mode == tpce_pkg::MODE_INSERT)
			cnt_mem[link_rd] <= cnt_inc;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q       <= '0;
			next_free_q <= tpce_pkg::FREE_W'(1);
			score_q     <= '0;
			status_q    <= tpce_pkg::ST_OK;
			clr_cnt_q   <= '0;
			done_q      <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (cmd.accept && item.mode == tpce_pkg::MODE_CLEAR) begin
				cur_q       <= '0;
				next_free_q <= tpce_pkg::FREE_W'(1);
				score_q     <= '0;
				status_q    <= tpce_pkg::ST_OK;
				clr_cnt_q   <= '0;
			end
			if (cmd.clear)
				clr_cnt_q <= sts.clr_last ? '0 : clr_cnt_q + 1'b1;
			if (alloc)
				next_free_q <= next_free_q + 1'b1;
			if (commit) begin
				if (item_q.word_end) begin
					cur_q    <= '0;
					score_q  <= '0;
					status_q <= tpce_pkg::ST_OK;
					done_q   <= 1'b1;
				end else begin
					cur_q    <= nx_cur;
					score_q  <= nx_score;
					status_q <= nx_status;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit && item_q.word_end) begin
			result_q.score  <= (nx_status == tpce_pkg::ST_OK
				&& item_q.mode == tpce_pkg::MODE_QUERY) ? nx_score : '0;
			result_q.status <= nx_status;
		end
	end

	assign done   = done_q;
	assign result = result_q;

	a_cur_allocated: assert property (@(posedge clk) disable iff (!arst_n)
		tpce_pkg::FREE_W'(cur_q) < next_free_q)
		else $error("current node lies beyond the allocated pool");

	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		next_free_q != '0 && next_free_q <= tpce_pkg::FREE_W'(tpce_pkg::NODE_POOL))
		else $error("free pointer out of range");

	a_error_score: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.status != tpce_pkg::ST_OK |-> result.score == '0)
		else $error("failed word reported a nonzero score");

	a_done_commit: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(commit) && $past(item_q.word_end))
		else $error("result strobe without a finished last letter");

endmodule

@@ rtl/trie_prefix_count_engine.sv @@
// ----------------------------------------------------------------------------
// trie_prefix_count_engine: letter-serial trie with saturating prefix counts
// Top level joining the sequencing controller and the node pool datapath.
// ----------------------------------------------------------------------------
// A letter is taken when start is high while busy is low. A letter whose child
// link exists steps through link and valid-row read, count read and count
// write-back; a letter that allocates a node or misses on a query ends after
// the lookup, and one that follows an earlier error in its word is skipped. A
// clear item, and likewise reset, holds busy high while all NODE_POOL valid rows
// are swept one per cycle. An unused mode is taken and dropped without raising busy. On a word's last
// letter done pulses for one cycle with score and status; the result must be
// captured in that cycle, since it cannot be held off.
module trie_prefix_count_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  tpce_pkg::item_t     item,
	output logic                busy,
	output logic                done,
	output tpce_pkg::result_t   result
);

	tpce_pkg::cmd_t cmd;
	tpce_pkg::sts_t sts;

	tpce_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.mode   (item.mode),
		.sts    (sts),
		.cmd    (cmd),
		.busy   (busy)
	);

	tpce_datapath u_datapath (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (cmd),
		.sts    (sts),
		.done   (done),
		.result (result)
	);

endmodule

@@ sim/tb_trie_prefix_count_engine.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_trie_prefix_count_engine: self-checking bench for the trie prefix counter
// Streams insert, query, clear and unused-mode items with random idle gaps and
// checks every result against a behavioral trie kept inside the bench. The
// stimulus covers the letter extremes, invalid letters, missing query paths,
// sticky errors and mixed modes within a word.
// ----------------------------------------------------------------------------
module tb_trie_prefix_count_engine;

	localparam logic [1:0] MODE_UNUSED = 2'd3;
	localparam int DICT_WORDS = 16;
	localparam int DICT_LEN   = 8;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	tpce_pkg::item_t   item = '0;
	logic              busy;
	logic              done;
	tpce_pkg::result_t result;

	trie_prefix_count_engine u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.done   (done),
		.result (result)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	tpce_pkg::item_t   letter_q[$];
	tpce_pkg::result_t word_results[$];
	int unsigned mismatch_count = 0;
	int unsigned fed_items = 0;
	int unsigned idle_left = 0;
	int unsigned calm_left = 0;

	// Behavioral copy of the trie.
	bit                          has_child [tpce_pkg::SLOTS];
	tpce_pkg::node_t             child_of  [tpce_pkg::SLOTS];
	tpce_pkg::count_t            prefix_cnt[tpce_pkg::NODE_POOL];
	tpce_pkg::node_t             cur_node;
	logic [tpce_pkg::FREE_W-1:0] free_node;
	logic [tpce_pkg::SCORE_W-1:0] score_acc;
	logic [1:0]                  word_st;

	function automatic void empty_trie();
		foreach (has_child[i]) has_child[i] = 1'b0;
		free_node = tpce_pkg::FREE_W'(1);
		cur_node  = '0;
		score_acc = '0;
		word_st   = tpce_pkg::ST_OK;
	endfunction

	function automatic void advance_trie(tpce_pkg::item_t it);
		int                           slot;
		tpce_pkg::node_t              nxt;
		logic [tpce_pkg::SCORE_W:0]   sum;
		tpce_pkg::result_t            r;
		if (it.mode == tpce_pkg::MODE_CLEAR) begin
			empty_trie();
			return;
		end
		if (it.mode == MODE_UNUSED)
			return;
		if (word_st == tpce_pkg::ST_OK) begin
			if (it.letter >= tpce_pkg::ALPHABET) begin
				word_st = tpce_pkg::ST_PATH_MISSING;
			end else begin
				slot = int'(cur_node) * tpce_pkg::ALPHABET + int'(it.letter);
				if (it.mode == tpce_pkg::MODE_INSERT) begin
					if (!has_child[slot]) begin
						if (free_node >= tpce_pkg::NODE_POOL) begin
							word_st = tpce_pkg::ST_POOL_FULL;
						end else begin
							child_of[slot]  = free_node[tpce_pkg::NODE_W-1:0];
							has_child[slot] = 1'b1;
							prefix_cnt[free_node[tpce_pkg::NODE_W-1:0]] = '0;
							free_node       = free_node + 1'b1;
						end
					end
					if (word_st == tpce_pkg::ST_OK) begin
						nxt = child_of[slot];
						if (prefix_cnt[nxt] != {tpce_pkg::COUNT_BITS{1'b1}})
							prefix_cnt[nxt] = prefix_cnt[nxt] + 1'b1;
						cur_node = nxt;
					end
				end else if (!has_child[slot]) begin
					word_st = tpce_pkg::ST_PATH_MISSING;
				end else begin
					nxt = child_of[slot];
					sum = {1'b0, score_acc} + (tpce_pkg::SCORE_W + 1)'(prefix_cnt[nxt]);
					score_acc = sum[tpce_pkg::SCORE_W] ? {tpce_pkg::SCORE_W{1'b1}}
						: sum[tpce_pkg::SCORE_W-1:0];
					cur_node = nxt;
				end
			end
		end
		if (it.word_end) begin
			r.score  = (word_st == tpce_pkg::ST_OK && it.mode == tpce_pkg::MODE_QUERY)
				? score_acc : '0;
			r.status = word_st;
			word_results = {word_results, r};
			cur_node  = '0;
			score_acc = '0;
			word_st   = tpce_pkg::ST_OK;
		end
	endfunction

	// Mostly short gaps, a few long ones, and runs of back-to-back transfers.
	function automatic int unsigned idle_len();
		int unsigned p;
		if (calm_left != 0) begin
			calm_left = calm_left - 1;
			return 0;
		end
		p = $urandom_range(0, 99);
		if (p < 3)
			calm_left = $urandom_range(10, 60);
		if (p < 65)
			return 0;
		if (p < 95)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start     <= 1'b0;
			item      <= '0;
			idle_left <= 0;
		end else begin
			if (start && !busy)
				advance_trie(item);
			if (start && busy) begin
				// Hold the item until the transfer happens.
			end else if (idle_left != 0) begin
				start     <= 1'b0;
				idle_left <= idle_left - 1;
			end else if (letter_q.size() != 0) begin
				start     <= 1'b1;
				item      <= letter_q.pop_front();
				idle_left <= idle_len();
			end else begin
				start <= 1'b0;
			end
		end
	end

	tpce_pkg::result_t want;

	always @(posedge clk) begin
		if (arst_n && done) begin
			if (word_results.size() == 0) begin
				$error("result with none expected: score %0d status %0d",
					result.score, result.status);
				mismatch_count++;
			end else begin
				want = word_results.pop_front();
				if (result.score !== want.score) begin
					$error("score: expected %0d, got %0d", want.score, result.score);
					mismatch_count++;
				end
				if (result.status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, result.status);
					mismatch_count++;
				end
			end
		end
	end

	logic [4:0]  dict_word[DICT_WORDS][DICT_LEN];
	int unsigned dict_len[DICT_WORDS];
	int unsigned dict_fill = 0;

	task automatic push_item(logic [1:0] m, logic [4:0] l, logic e);
		tpce_pkg::item_t it;
		it.mode     = m;
		it.letter   = l;
		it.word_end = e;
		letter_q = {letter_q, it};
		if (m != MODE_UNUSED)
			fed_items++;
	endtask

	task automatic push_dict(logic [1:0] m, int unsigned k, int unsigned n);
		for (int unsigned i = 0; i < n; i++)
			push_item(m, dict_word[k][i], i == n - 1);
	endtask

	task automatic make_word();
		int unsigned k;
		bit          narrow;
		k = dict_fill % DICT_WORDS;
		narrow = $urandom_range(0, 3) != 0;
		dict_len[k] = $urandom_range(1, DICT_LEN);
		for (int unsigned i = 0; i < dict_len[k]; i++)
			dict_word[k][i] = narrow ? 5'($urandom_range(0, 3))
				: 5'($urandom_range(0, tpce_pkg::ALPHABET - 1));
		dict_fill++;
		push_dict(tpce_pkg::MODE_INSERT, k, dict_len[k]);
	endtask

	task automatic make_noise_word();
		int unsigned n;
		logic [1:0]  m;
		logic [4:0]  l;
		n = $urandom_range(1, 6);
		for (int unsigned i = 0; i < n; i++) begin
			m = 2'($urandom_range(0, 1));
			l = ($urandom_range(0, 5) == 0) ? 5'($urandom_range(0, 31))
				: 5'($urandom_range(0, 3));
			if ($urandom_range(0, 19) == 0)
				push_item(MODE_UNUSED, 5'($urandom_range(0, 31)),
					1'($urandom_range(0, 1)));
			if ($urandom_range(0, 29) == 0)
				push_item(tpce_pkg::MODE_CLEAR, 5'($urandom_range(0, 31)),
					1'($urandom_range(0, 1)));
			push_item(m, l, i == n - 1);
		end
	endtask

	initial begin
		int unsigned pick;
		int unsigned k;

		empty_trie();

		// Directed part.
		push_item(tpce_pkg::MODE_QUERY, 5'd0, 1'b1);    // query on an empty trie
		push_item(tpce_pkg::MODE_INSERT, 5'd0, 1'b1);   // "a"
		push_item(tpce_pkg::MODE_INSERT, 5'd25, 1'b0);  // "za"
		push_item(tpce_pkg::MODE_INSERT, 5'd0, 1'b1);
		push_item(tpce_pkg::MODE_QUERY, 5'd0, 1'b1);
		push_item(tpce_pkg::MODE_QUERY, 5'd25, 1'b0);
		push_item(tpce_pkg::MODE_QUERY, 5'd0, 1'b1);
		push_item(tpce_pkg::MODE_INSERT, 5'd31, 1'b1);  // invalid letters
		push_item(tpce_pkg::MODE_QUERY, 5'd26, 1'b1);
		push_item(tpce_pkg::MODE_QUERY, 5'd3, 1'b0);    // error stays with the word
		push_item(tpce_pkg::MODE_QUERY, 5'd0, 1'b0);
		push_item(tpce_pkg::MODE_INSERT, 5'd1, 1'b1);
		push_item(tpce_pkg::MODE_INSERT, 5'd25, 1'b0);  // mixed modes in one word
		push_item(tpce_pkg::MODE_QUERY, 5'd0, 1'b1);
		push_item(tpce_pkg::MODE_QUERY, 5'd25, 1'b0);
		push_item(tpce_pkg::MODE_INSERT, 5'd16, 1'b1);
		push_item(MODE_UNUSED, 5'd31, 1'b1);            // ignored mode
		push_item(tpce_pkg::MODE_INSERT, 5'd16, 1'b1);
		push_item(tpce_pkg::MODE_QUERY, 5'd16, 1'b1);
		push_item(tpce_pkg::MODE_CLEAR, 5'd31, 1'b1);   // clear gives no result
		push_item(tpce_pkg::MODE_QUERY, 5'd0, 1'b1);

		// Random part: mostly real words over a small dictionary.
		for (int i = 0; i < 4; i++)
			make_word();
		while (fed_items < 600) begin
			pick = $urandom_range(0, 99);
			k = $urandom_range(0, DICT_WORDS - 1) % (dict_fill < DICT_WORDS ? dict_fill : DICT_WORDS);
			if (pick < 25)
				make_word();
			else if (pick < 40)
				push_dict(tpce_pkg::MODE_INSERT, k, dict_len[k]);
			else if (pick < 72)
				push_dict(tpce_pkg::MODE_QUERY, k, $urandom_range(1, dict_len[k]));
			else if (pick < 80)
				push_item(tpce_pkg::MODE_QUERY,
					5'($urandom_range(0, tpce_pkg::ALPHABET - 1)), 1'b1);
			else if (pick < 92)
				make_noise_word();
			else if (pick < 95)
				push_item(MODE_UNUSED, 5'($urandom_range(0, 31)),
					1'($urandom_range(0, 1)));
			else if (pick < 97)
				push_item(tpce_pkg::MODE_CLEAR, 5'($urandom_range(0, 31)),
					1'($urandom_range(0, 1)));
			else
				push_item(2'($urandom_range(0, 1)),
					5'($urandom_range(tpce_pkg::ALPHABET, 31)), 1'b1);
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (letter_q.size() != 0 || start)
			@(posedge clk);
		while (word_results.size() != 0)
			@(posedge clk);
		repeat (16) @(posedge clk);

		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

	initial begin
		#100_000_000;
		$display("Mismatches found");
		$finish;
	end

endmodule

@@ sim.f @@
rtl/tpce_pkg.sv
rtl/tpce_ctrl.sv
rtl/tpce_datapath.sv
rtl/trie_prefix_count_engine.sv
sim/tb_trie_prefix_count_engine.sv
